@@ rtl/isp_pkg.sv @@
// Package for the immigrant slot pool: transaction structs, register indexes,
// result codes, the fetch sequencer states and default sizes. No dependencies.
`timescale 1ns / 1ps

package isp_pkg;

    localparam int SLOTS_DEF        = 32;
    localparam int MAX_RECORDS_DEF  = 4;
    localparam int RECORD_WORDS_DEF = 64;
    localparam int HDR_WORDS        = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SLOTS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMS_PER_MSG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROM_WORDS    = 2'd2;

    localparam logic [5:0] POOL_SLOTS_RST     = 6'd32;
    localparam logic [2:0] CHROMS_PER_MSG_RST = 3'd2;
    localparam logic [5:0] CHROM_WORDS_RST    = 6'd16;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    localparam logic signed [31:0] ORIGIN_NONE = -32'sd1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         status;
        logic signed [31:0] value;
        logic signed [31:0] origin;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic claim;
        logic release_slot;
    } slot_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TYPE,
        ST_ORIG,
        ST_PAY
    } fetch_state_t;

endpackage

@@ rtl/isp_word_ram.sv @@
// Slot word memory: one write port, one read port, registered read data.
// Address is formed from slot, record and word offset. Uses isp_pkg.
`timescale 1ns / 1ps

module isp_word_ram import isp_pkg::*; #(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
    parameter int RECORD_WORDS = RECORD_WORDS_DEF,
    localparam int HEAD_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int REC_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
    localparam int OFF_W  = $clog2(RECORD_WORDS)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [HEAD_W-1:0] wr_slot,
    input  logic [REC_W-1:0]  wr_rec,
    input  logic [OFF_W-1:0]  wr_off,
    input  logic [31:0]       wr_data,
    input  logic              rd_en,
    input  logic [HEAD_W-1:0] rd_slot,
    input  logic [REC_W-1:0]  rd_rec,
    input  logic [OFF_W-1:0]  rd_off,
    output logic [31:0]       rd_data
);

    localparam int DEPTH = SLOTS * MAX_RECORDS * RECORD_WORDS;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0]   mem [DEPTH];
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [31:0]   rd_data_reg;

    assign waddr = AW'((int'(wr_slot) * MAX_RECORDS + int'(wr_rec)) * RECORD_WORDS
                       + int'(wr_off));
    assign raddr = AW'((int'(rd_slot) * MAX_RECORDS + int'(rd_rec)) * RECORD_WORDS
                       + int'(rd_off));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/isp_slot_table.sv @@
// Slot table: in-use bits, record index per slot, head and write slot.
// Claims a slot on a message start, releases it after its last record. Uses isp_pkg.
`timescale 1ns / 1ps

module isp_slot_table import isp_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int HEAD_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CNT_W  = $clog2(SLOTS + 1),
    localparam int REC_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
    localparam int RECS_W = $clog2(MAX_RECORDS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  slot_cmd_t         cmd,
    input  logic [CNT_W-1:0]  pool_eff,
    input  logic [RECS_W-1:0] recs_eff,
    output logic              head_used,
    output logic [HEAD_W-1:0] head_slot,
    output logic [REC_W-1:0]  head_rec,
    output logic [HEAD_W-1:0] claim_slot,
    output logic [HEAD_W-1:0] write_slot
);

    logic [SLOTS-1:0]  used_reg;
    logic [REC_W-1:0]  rec_reg [SLOTS];
    logic [HEAD_W-1:0] head_reg;
    logic [HEAD_W-1:0] write_slot_reg;

    logic [HEAD_W-1:0] head_inc;
    logic [HEAD_W-1:0] head_prev;
    logic [RECS_W:0]   rec_next;
    logic              rec_done;

    always_comb begin
        if ((CNT_W'(head_reg) + CNT_W'(1)) >= pool_eff) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + HEAD_W'(1);
        end
        if (head_reg == '0) begin
            head_prev = HEAD_W'(pool_eff - CNT_W'(1));
        end else begin
            head_prev = head_reg - HEAD_W'(1);
        end
    end

    assign claim_slot = used_reg[head_reg] ? head_inc : head_reg;
    assign rec_next   = (RECS_W + 1)'(rec_reg[head_reg]) + (RECS_W + 1)'(1);
    assign rec_done   = rec_next >= (RECS_W + 1)'(recs_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            head_reg       <= '0;
            write_slot_reg <= '0;
        end else if (cmd.claim) begin
            used_reg[claim_slot] <= 1'b1;
            head_reg             <= claim_slot;
            write_slot_reg       <= claim_slot;
        end else if (cmd.release_slot && rec_done) begin
            used_reg[head_reg] <= 1'b0;
            if (used_reg[head_prev]) begin
                head_reg <= head_prev;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.claim) begin
            rec_reg[claim_slot] <= '0;
        end else if (cmd.release_slot) begin
            rec_reg[head_reg] <= rec_done ? '0 : REC_W'(rec_next);
        end
    end

    assign head_used  = used_reg[head_reg];
    assign head_slot  = head_reg;
    assign head_rec   = rec_reg[head_reg];
    assign write_slot = write_slot_reg;

    a_no_claim_and_release: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.claim && cmd.release_slot))
        else $error("claim and release in one cycle");

    a_claimed_slot_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.claim |=> used_reg[write_slot_reg] && (head_reg == write_slot_reg))
        else $error("claimed slot not marked in use");

    a_release_needs_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.release_slot |-> used_reg[head_reg])
        else $error("release of a free slot");

endmodule

@@ rtl/immigrant_slot_pool_top.sv @@
// Immigrant slot pool top: config registers, message write path, fetch
// sequencer and output register. Uses isp_pkg, isp_word_ram, isp_slot_table.
//
//   channel   ports                       dir  content
//   cfg       cfg_wr_en/index/wdata       in   register writes, no wait
//   s_        s_valid/s_ready/s_data      in   in_item_t: mode, word
//   m_        m_valid/m_ready/m_data      out  out_item_t: kind..last
//
// Message words stream one per cycle while no fetch runs and the output is free.
// A fetch makes two word-memory reads for the header, then reads one payload word
// per cycle from the single read port while m_ready does not stall the output.
// A stalled m_ready holds the sequencer; read data stays registered.
// Synchronous active-low reset clears the slot table and counters; no clearing pass.
`timescale 1ns / 1ps

module immigrant_slot_pool_top import isp_pkg::*; #(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
    parameter int RECORD_WORDS = RECORD_WORDS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int HEAD_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int REC_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int RECS_W = $clog2(MAX_RECORDS + 1);
    localparam int OFF_W  = $clog2(RECORD_WORDS);
    localparam int RLEN_W = $clog2(RECORD_WORDS + 1);
    localparam int WC_W   = $clog2(MAX_RECORDS * RECORD_WORDS);
    localparam int MLEN_W = $clog2(MAX_RECORDS * RECORD_WORDS + 1);

    logic [5:0] pool_slots_reg;
    logic [2:0] chroms_per_msg_reg;
    logic [5:0] chrom_words_reg;

    logic [CNT_W-1:0]  pool_eff;
    logic [RECS_W-1:0] recs_eff;
    logic [OFF_W-1:0]  pay_eff;
    logic [RLEN_W-1:0] rlen;
    logic [MLEN_W-1:0] mlen;

    logic [WC_W-1:0]  word_count_reg;
    logic             drop_reg;
    fetch_state_t     state_reg;
    fetch_state_t     state_next;
    logic [OFF_W-1:0] pay_cnt_reg;
    logic [31:0]      type_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic              out_free;
    logic              s_fire;
    logic              msg_fire;
    logic              fetch_fire;
    logic              first_word;
    logic              drop_now;
    logic              pay_last;
    logic [MLEN_W-1:0] acc;
    logic [MLEN_W-1:0] base;
    logic [REC_W-1:0]  msg_rec;
    logic [OFF_W-1:0]  msg_off;
    logic              rec_over;

    logic              out_load;
    out_item_t         out_next;
    logic              rd_en;
    logic [OFF_W-1:0]  rd_off;
    logic [31:0]       rd_data;
    slot_cmd_t         cmd;

    logic              head_used;
    logic [HEAD_W-1:0] head_slot;
    logic [REC_W-1:0]  head_rec;
    logic [HEAD_W-1:0] claim_slot;
    logic [HEAD_W-1:0] write_slot;
    logic [HEAD_W-1:0] wr_slot;
    logic              wr_en;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_slots_reg     <= POOL_SLOTS_RST;
            chroms_per_msg_reg <= CHROMS_PER_MSG_RST;
            chrom_words_reg    <= CHROM_WORDS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POOL_SLOTS:     pool_slots_reg     <= cfg_wdata;
                CFG_CHROMS_PER_MSG: chroms_per_msg_reg <= cfg_wdata[2:0];
                CFG_CHROM_WORDS:    chrom_words_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (pool_slots_reg == '0) begin
            pool_eff = CNT_W'(1);
        end else if (int'(pool_slots_reg) > SLOTS) begin
            pool_eff = CNT_W'(SLOTS);
        end else begin
            pool_eff = CNT_W'(pool_slots_reg);
        end
        if (chroms_per_msg_reg == '0) begin
            recs_eff = RECS_W'(1);
        end else if (int'(chroms_per_msg_reg) > MAX_RECORDS) begin
            recs_eff = RECS_W'(MAX_RECORDS);
        end else begin
            recs_eff = RECS_W'(chroms_per_msg_reg);
        end
        if (chrom_words_reg == '0) begin
            pay_eff = OFF_W'(1);
        end else if (int'(chrom_words_reg) > RECORD_WORDS - HDR_WORDS) begin
            pay_eff = OFF_W'(RECORD_WORDS - HDR_WORDS);
        end else begin
            pay_eff = OFF_W'(chrom_words_reg);
        end
    end

    assign rlen = RLEN_W'(pay_eff) + RLEN_W'(HDR_WORDS);
    assign mlen = MLEN_W'(recs_eff) * MLEN_W'(rlen);

    // record and offset of the current message word
    always_comb begin
        acc      = '0;
        base     = '0;
        msg_rec  = '0;
        rec_over = 1'b0;
        for (int k = 1; k <= MAX_RECORDS; k++) begin
            acc = acc + MLEN_W'(rlen);
            if (acc <= MLEN_W'(word_count_reg)) begin
                if (k == MAX_RECORDS) begin
                    rec_over = 1'b1;
                end else begin
                    msg_rec = REC_W'(k);
                    base    = acc;
                end
            end
        end
    end

    assign msg_off = OFF_W'(MLEN_W'(word_count_reg) - base);

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign s_fire     = s_valid && s_ready;
    assign msg_fire   = s_fire && !s_data.mode;
    assign fetch_fire = s_fire && s_data.mode;
    assign first_word = word_count_reg == '0;
    assign drop_now   = first_word ? (s_data.word == '0) : drop_reg;
    assign pay_last   = pay_cnt_reg == (pay_eff - OFF_W'(1));

    assign wr_en   = msg_fire && !drop_now && !rec_over;
    assign wr_slot = first_word ? claim_slot : write_slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg <= '0;
            drop_reg       <= 1'b0;
        end else if (msg_fire) begin
            if ((MLEN_W'(word_count_reg) + MLEN_W'(1)) >= mlen) begin
                word_count_reg <= '0;
                drop_reg       <= 1'b0;
            end else begin
                word_count_reg <= word_count_reg + WC_W'(1);
                drop_reg       <= drop_now;
            end
        end
    end

    // fetch sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (fetch_fire && first_word && head_used) begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE: state_next = ST_ORIG;
            ST_ORIG: begin
                if (out_free) begin
                    state_next = ST_PAY;
                end
            end
            ST_PAY: begin
                if (out_free && pay_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_load         = 1'b0;
        out_next         = '0;
        rd_en            = 1'b0;
        rd_off           = '0;
        cmd.claim        = msg_fire && first_word && (s_data.word != '0);
        cmd.release_slot = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (msg_fire) begin
                    out_load        = 1'b1;
                    out_next.kind   = KIND_STATUS;
                    out_next.status = drop_now ? STAT_DROPPED : STAT_OK;
                    out_next.last   = 1'b1;
                end else if (fetch_fire) begin
                    if (!first_word) begin
                        out_load        = 1'b1;
                        out_next.kind   = KIND_STATUS;
                        out_next.status = STAT_REFUSED;
                        out_next.last   = 1'b1;
                    end else if (!head_used) begin
                        out_load        = 1'b1;
                        out_next.kind   = KIND_HEADER;
                        out_next.origin = ORIGIN_NONE;
                        out_next.last   = 1'b1;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_TYPE: begin
                rd_en  = 1'b1;
                rd_off = OFF_W'(1);
            end
            ST_ORIG: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_next.kind   = KIND_HEADER;
                    out_next.value  = type_reg;
                    out_next.origin = rd_data;
                    rd_en           = 1'b1;
                    rd_off          = OFF_W'(HDR_WORDS);
                end
            end
            ST_PAY: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_next.kind  = KIND_PAYLOAD;
                    out_next.value = rd_data;
                    out_next.last  = pay_last;
                    if (pay_last) begin
                        cmd.release_slot = 1'b1;
                    end else begin
                        rd_en  = 1'b1;
                        rd_off = OFF_W'(HDR_WORDS) + pay_cnt_reg + OFF_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pay_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ORIG) begin
                pay_cnt_reg <= '0;
            end else if (state_reg == ST_PAY && out_free) begin
                pay_cnt_reg <= pay_cnt_reg + OFF_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_TYPE) begin
            type_reg <= rd_data;
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    isp_slot_table #(
        .SLOTS       (SLOTS),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_slot_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .pool_eff   (pool_eff),
        .recs_eff   (recs_eff),
        .head_used  (head_used),
        .head_slot  (head_slot),
        .head_rec   (head_rec),
        .claim_slot (claim_slot),
        .write_slot (write_slot)
    );

    isp_word_ram #(
        .SLOTS        (SLOTS),
        .MAX_RECORDS  (MAX_RECORDS),
        .RECORD_WORDS (RECORD_WORDS)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_slot (wr_slot),
        .wr_rec  (msg_rec),
        .wr_off  (msg_off),
        .wr_data (s_data.word),
        .rd_en   (rd_en),
        .rd_slot (head_slot),
        .rd_rec  (head_rec),
        .rd_off  (rd_off),
        .rd_data (rd_data)
    );

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("input taken during a fetch");

    a_fetch_between_messages: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> word_count_reg == '0)
        else $error("fetch running mid-message");

    a_type_then_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TYPE) |=> (state_reg == ST_ORIG))
        else $error("header read sequence broken");

    a_last_payload_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAY && out_free && pay_last) |=>
            (state_reg == ST_IDLE) && m_valid_reg && m_data_reg.last)
        else $error("fetch did not end on its last payload word");

endmodule
